FILE: hw/rtl/rsid_pkg.sv
// Shared types and codes for the RV32IM subset instruction decoder.
// Depends on nothing; every other file of the decoder imports it.
package rsid_pkg;

  localparam int WORD_W = 32;
  localparam int REG_W  = 5;
  localparam int MNEM_W = 5;
  localparam int STAT_W = 2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_VALID   = 2'd0;
  localparam logic [STAT_W-1:0] ST_BUBBLE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

  // Major opcodes.
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  // funct7 values.
  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT    = 7'h20;

  // funct3 values.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_BNE  = 3'd1;

  // Mnemonic codes.
  localparam logic [MNEM_W-1:0] M_ADD   = 5'd0;
  localparam logic [MNEM_W-1:0] M_MUL   = 5'd1;
  localparam logic [MNEM_W-1:0] M_SUB   = 5'd2;
  localparam logic [MNEM_W-1:0] M_SLL   = 5'd3;
  localparam logic [MNEM_W-1:0] M_MULH  = 5'd4;
  localparam logic [MNEM_W-1:0] M_SLT   = 5'd5;
  localparam logic [MNEM_W-1:0] M_XOR   = 5'd6;
  localparam logic [MNEM_W-1:0] M_DIV   = 5'd7;
  localparam logic [MNEM_W-1:0] M_SRL   = 5'd8;
  localparam logic [MNEM_W-1:0] M_SRA   = 5'd9;
  localparam logic [MNEM_W-1:0] M_OR    = 5'd10;
  localparam logic [MNEM_W-1:0] M_REM   = 5'd11;
  localparam logic [MNEM_W-1:0] M_AND   = 5'd12;
  localparam logic [MNEM_W-1:0] M_ADDI  = 5'd13;
  localparam logic [MNEM_W-1:0] M_SLLI  = 5'd14;
  localparam logic [MNEM_W-1:0] M_SLTI  = 5'd15;
  localparam logic [MNEM_W-1:0] M_XORI  = 5'd16;
  localparam logic [MNEM_W-1:0] M_SRLI  = 5'd17;
  localparam logic [MNEM_W-1:0] M_SRAI  = 5'd18;
  localparam logic [MNEM_W-1:0] M_ORI   = 5'd19;
  localparam logic [MNEM_W-1:0] M_ANDI  = 5'd20;
  localparam logic [MNEM_W-1:0] M_LB    = 5'd21;
  localparam logic [MNEM_W-1:0] M_SB    = 5'd24;
  localparam logic [MNEM_W-1:0] M_BEQ   = 5'd27;
  localparam logic [MNEM_W-1:0] M_BNE   = 5'd28;
  localparam logic [MNEM_W-1:0] M_LUI   = 5'd29;
  localparam logic [MNEM_W-1:0] M_JAL   = 5'd30;
  localparam logic [MNEM_W-1:0] M_ECALL = 5'd31;

  // Immediate formats.
  typedef enum logic [2:0] {
    IMM_NONE  = 3'd0,
    IMM_I     = 3'd1,
    IMM_SHAMT = 3'd2,
    IMM_S     = 3'd3,
    IMM_B     = 3'd4,
    IMM_J     = 3'd5,
    IMM_U     = 3'd6
  } imm_fmt_t;

  // Control decode handed from the opcode decoder to the rest of the block.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [MNEM_W-1:0] mnemonic;
    imm_fmt_t          imm_fmt;
  } decode_t;

endpackage

FILE: hw/rtl/rsid_decode.sv
// Opcode/funct decoder: status, mnemonic and immediate format of one word.
// Depends on rsid_pkg.
module rsid_decode
  import rsid_pkg::*;
(
  input  logic [WORD_W-1:0] word,
  output decode_t           dec
);

  logic [6:0]        opcode;
  logic [2:0]        f3;
  logic [6:0]        f7;
  logic [MNEM_W-1:0] mnem;
  imm_fmt_t          fmt;
  logic              bad;

  assign opcode = word[6:0];
  assign f3     = word[14:12];
  assign f7     = word[31:25];

  always_comb begin
    mnem = '0;
    fmt  = IMM_NONE;
    bad  = 1'b0;
    unique case (opcode)
      OPC_OP: begin
        unique case (f3)
          F3_ADD: begin
            if (f7 == F7_BASE) mnem = M_ADD;
            else if (f7 == F7_MULDIV) mnem = M_MUL;
            else if (f7 == F7_ALT) mnem = M_SUB;
            else bad = 1'b1;
          end
          F3_SLL: begin
            if (f7 == F7_BASE) mnem = M_SLL;
            else if (f7 == F7_MULDIV) mnem = M_MULH;
            else bad = 1'b1;
          end
          F3_SLT: begin
            if (f7 == F7_BASE) mnem = M_SLT;
            else bad = 1'b1;
          end
          F3_XOR: begin
            if (f7 == F7_BASE) mnem = M_XOR;
            else if (f7 == F7_MULDIV) mnem = M_DIV;
            else bad = 1'b1;
          end
          F3_SR: begin
            if (f7 == F7_BASE) mnem = M_SRL;
            else if (f7 == F7_ALT) mnem = M_SRA;
            else bad = 1'b1;
          end
          F3_OR: begin
            if (f7 == F7_BASE) mnem = M_OR;
            else if (f7 == F7_MULDIV) mnem = M_REM;
            else bad = 1'b1;
          end
          F3_AND: begin
            if (f7 == F7_BASE) mnem = M_AND;
            else bad = 1'b1;
          end
          default: bad = 1'b1;
        endcase
      end
      OPC_OP_IMM: begin
        unique case (f3)
          F3_ADD: begin
            mnem = M_ADDI;
            fmt  = IMM_I;
          end
          F3_SLL: begin
            if (f7 == F7_BASE) begin
              mnem = M_SLLI;
              fmt  = IMM_SHAMT;
            end else begin
              bad = 1'b1;
            end
          end
          F3_SLT: begin
            mnem = M_SLTI;
            fmt  = IMM_I;
          end
          F3_XOR: begin
            mnem = M_XORI;
            fmt  = IMM_I;
          end
          F3_SR: begin
            if (f7 == F7_BASE) begin
              mnem = M_SRLI;
              fmt  = IMM_SHAMT;
            end else if (f7 == F7_ALT) begin
              mnem = M_SRAI;
              fmt  = IMM_SHAMT;
            end else begin
              bad = 1'b1;
            end
          end
          F3_OR: begin
            mnem = M_ORI;
            fmt  = IMM_I;
          end
          F3_AND: begin
            mnem = M_ANDI;
            fmt  = IMM_I;
          end
          default: bad = 1'b1;
        endcase
      end
      OPC_LOAD: begin
        // Byte, half and word sit at consecutive codes.
        if (f3 <= F3_WORD) begin
          mnem = M_LB + MNEM_W'(f3);
          fmt  = IMM_I;
        end else begin
          bad = 1'b1;
        end
      end
      OPC_STORE: begin
        if (f3 <= F3_WORD) begin
          mnem = M_SB + MNEM_W'(f3);
          fmt  = IMM_S;
        end else begin
          bad = 1'b1;
        end
      end
      OPC_BRANCH: begin
        if (f3 == F3_BNE) begin
          mnem = M_BNE;
          fmt  = IMM_B;
        end else if (f3 == F3_ADD) begin
          mnem = M_BEQ;
          fmt  = IMM_B;
        end else begin
          bad = 1'b1;
        end
      end
      OPC_LUI: begin
        mnem = M_LUI;
        fmt  = IMM_U;
      end
      OPC_JAL: begin
        mnem = M_JAL;
        fmt  = IMM_J;
      end
      // Every word with the system opcode is taken as ecall.
      OPC_SYSTEM: mnem = M_ECALL;
      default: bad = 1'b1;
    endcase
  end

  always_comb begin
    dec.mnemonic = mnem;
    dec.imm_fmt  = fmt;
    if (word == '0) dec.status = ST_BUBBLE;
    else if (bad) dec.status = ST_INVALID;
    else dec.status = ST_VALID;
  end

endmodule

FILE: hw/rtl/rsid_imm.sv
// Immediate generator: assembles the immediate of each format, sign-extending the I, S, B and J formats.
// Depends on rsid_pkg.
module rsid_imm
  import rsid_pkg::*;
(
  input  logic [WORD_W-1:0] word,
  input  imm_fmt_t          fmt,
  output logic [WORD_W-1:0] imm
);

  always_comb begin
    unique case (fmt)
      IMM_I:     imm = {{20{word[31]}}, word[31:20]};
      IMM_SHAMT: imm = {27'd0, word[24:20]};
      IMM_S:     imm = {{20{word[31]}}, word[31:25], word[11:7]};
      IMM_B:     imm = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
      IMM_J:     imm = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
      IMM_U:     imm = {word[31:12], 12'd0};
      default:   imm = '0;
    endcase
  end

endmodule

FILE: hw/rtl/riscv_subset_instruction_decoder_top.sv
// Top level of the RV32IM subset instruction decoder: input register, decode
// logic and result register. Depends on rsid_pkg, rsid_decode and rsid_imm.
//
// A request is taken on every clock edge where start is high; busy never rises,
// so one instruction word can be presented each cycle. The word is captured in the
// input register and its decode is loaded into the result register, with done
// registered from the input valid flag alongside it. The result is valid for a
// single cycle only, since there is no result backpressure.
// Results leave in request order. Non-valid results carry zero in all fields
// but status.
module riscv_subset_instruction_decoder_top
  import rsid_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [WORD_W-1:0]        instr_word,
  output logic                     done,
  output logic [STAT_W-1:0]        status,
  output logic [MNEM_W-1:0]        mnemonic,
  output logic [REG_W-1:0]         dest_reg,
  output logic [REG_W-1:0]         src1_reg,
  output logic [REG_W-1:0]         src2_reg,
  output logic signed [WORD_W-1:0] immediate
);

  logic              in_valid;
  logic [WORD_W-1:0] in_word;
  decode_t           dec;
  logic [WORD_W-1:0] imm_raw;
  logic              ok;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_word <= instr_word;
    end
  end

  rsid_decode u_decode (
    .word (in_word),
    .dec  (dec)
  );

  rsid_imm u_imm (
    .word (in_word),
    .fmt  (dec.imm_fmt),
    .imm  (imm_raw)
  );

  assign ok = (dec.status == ST_VALID);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      status    <= dec.status;
      mnemonic  <= ok ? dec.mnemonic : '0;
      dest_reg  <= ok ? in_word[11:7] : '0;
      src1_reg  <= ok ? in_word[19:15] : '0;
      src2_reg  <= ok ? in_word[24:20] : '0;
      immediate <= ok ? signed'(imm_raw) : '0;
    end
  end

endmodule

FILE: hw/rtl/rsid_checker.sv
// Port-level checker for the instruction decoder top level, with its bind.
// Depends on rsid_pkg and riscv_subset_instruction_decoder_top.
module rsid_checker
  import rsid_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic [WORD_W-1:0]        instr_word,
  input logic                     done,
  input logic [STAT_W-1:0]        status,
  input logic [MNEM_W-1:0]        mnemonic,
  input logic [REG_W-1:0]         dest_reg,
  input logic [REG_W-1:0]         src1_reg,
  input logic [REG_W-1:0]         src2_reg,
  input logic signed [WORD_W-1:0] immediate
);

  // Every request yields its result.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("request without a result two cycles later");

  // No result appears without a request behind it.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##2 !done)
    else $error("result without a request");

  // An all-zero word decodes as a bubble.
  a_bubble: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && instr_word == '0) |-> ##2 (done && status == ST_BUBBLE))
    else $error("zero word not reported as a bubble");

  // A result that is not valid carries nothing but its status.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_VALID) |->
      (mnemonic == '0 && dest_reg == '0 && src1_reg == '0 && src2_reg == '0 &&
       immediate == '0 && (status == ST_BUBBLE || status == ST_INVALID)))
    else $error("non-valid result with nonzero fields or unknown status");

endmodule

bind riscv_subset_instruction_decoder_top rsid_checker u_rsid_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .instr_word (instr_word),
  .done       (done),
  .status     (status),
  .mnemonic   (mnemonic),
  .dest_reg   (dest_reg),
  .src1_reg   (src1_reg),
  .src2_reg   (src2_reg),
  .immediate  (immediate)
);
